### hw/rtl/skt_pkg.sv
// Shared types and constants for the sorted key table.
`default_nettype none
package skt_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 30;
  localparam int SCORE_W  = 8;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = 5;
  localparam int AVG_W    = 9;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_DELETED   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic [KEY_W-1:0]   student_key;
    logic [SCORE_W-1:0] score_a;
    logic [SCORE_W-1:0] score_b;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ENTRY_W-1:0] entry_count;
    logic [SCORE_W-1:0] removed_score_a;
    logic [SCORE_W-1:0] removed_score_b;
    logic [AVG_W-1:0]   removed_avg_x2;
  } out_item_t;

  // One stored record
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score_a;
    logic [SCORE_W-1:0] score_b;
  } rec_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic del_en;
    rec_t rec;
  } cell_ctl_t;

endpackage
`default_nettype wire

### hw/rtl/skt_cell.sv
// One slot of the sorted table: compares, shifts left or right, and reports a hit.
`default_nettype none
module skt_cell (
  input  wire logic              clk,
  input  wire skt_pkg::cell_ctl_t ctl,
  input  wire logic              occ,
  input  wire logic              gt_in,
  output logic                   gt_out,
  input  wire logic              hit_in,
  output logic                   hit_out,
  input  wire skt_pkg::rec_t     left_rec,
  input  wire skt_pkg::rec_t     right_rec,
  output skt_pkg::rec_t          rec_q,
  output skt_pkg::rec_t          rem_rec
);
  import skt_pkg::*;

  rec_t rec_r;
  rec_t rec_nxt;
  logic gt;
  logic match;

  // Compare the broadcast key against this slot
  assign gt      = occ && (ctl.rec.key > rec_r.key);
  assign match   = occ && (ctl.rec.key == rec_r.key);
  assign gt_out  = gt;
  assign hit_out = hit_in | match;
  assign rec_q   = rec_r;

  // Drive the removed record only from the first matching slot
  assign rem_rec = (match && !hit_in) ? rec_r : '0;

  // Hold, take the new record, or shift from a neighbor
  always_comb begin
    rec_nxt = rec_r;
    if (ctl.ins_en) begin
      if (!gt) begin
        rec_nxt = gt_in ? ctl.rec : left_rec;
      end
    end else if (ctl.del_en) begin
      if (hit_in || match) begin
        rec_nxt = right_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/sorted_key_table_insert_delete.sv
// Top level of the sorted key table: cell chain, fill count and result register.
//
//  channel | ports                 | handshake
//  --------+-----------------------+----------------------------------------
//  input   | start, busy, in_item  | transfer when start high and busy low
//  result  | out_valid, out_item   | one-cycle strobe, receiver cannot stall
//
// All cells compare and shift in parallel at the transfer edge, and the result
// strobes on the next cycle. busy stays low, so a new operation can be taken
// every cycle. Reset (rst_n, synchronous) clears the fill count and the result
// strobe; record contents are left as is.
`default_nettype none
module sorted_key_table_insert_delete (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire skt_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output skt_pkg::out_item_t      out_item
);
  import skt_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_item_t        out_r;
  out_item_t        out_nxt;

  logic      accept;
  logic      full;
  logic      found;
  cell_ctl_t ctl;
  rec_t      rem;

  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] hit;
  rec_t                rec_q   [CAPACITY];
  rec_t                rem_rec [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(CAPACITY));

  // Broadcast the operation to the chain
  always_comb begin
    ctl.ins_en      = accept && (in_item.cmd == CMD_INSERT) && !full;
    ctl.del_en      = accept && (in_item.cmd == CMD_DELETE);
    ctl.rec.key     = in_item.student_key;
    ctl.rec.score_a = in_item.score_a;
    ctl.rec.score_b = in_item.score_b;
  end

  // Build the cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rec_t left_rec;
    rec_t right_rec;
    logic gt_in;
    logic hit_in;

    assign occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign left_rec = ctl.rec;
      assign gt_in    = 1'b1;
      assign hit_in   = 1'b0;
    end else begin : g_inner
      assign left_rec = rec_q[i-1];
      assign gt_in    = gt[i-1];
      assign hit_in   = hit[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_rec = rec_q[i];
    end else begin : g_mid
      assign right_rec = rec_q[i+1];
    end

    skt_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ[i]),
      .gt_in     (gt_in),
      .gt_out    (gt[i]),
      .hit_in    (hit_in),
      .hit_out   (hit[i]),
      .left_rec  (left_rec),
      .right_rec (right_rec),
      .rec_q     (rec_q[i]),
      .rem_rec   (rem_rec[i])
    );
  end

  assign found = hit[CAPACITY-1];

  // Merge the removed record; at most one cell drives a nonzero value
  always_comb begin
    rem = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rem = rem | rem_rec[i];
    end
  end

  // Advance the count and form the result
  always_comb begin
    count_nxt = count_r;
    out_nxt   = '0;
    if (in_item.cmd == CMD_INSERT) begin
      if (full) begin
        out_nxt.status = ST_FULL;
      end else begin
        count_nxt      = count_r + CNT_W'(1);
        out_nxt.status = ST_INSERTED;
      end
    end else begin
      if (found) begin
        count_nxt               = count_r - CNT_W'(1);
        out_nxt.status          = ST_DELETED;
        out_nxt.removed_score_a = rem.score_a;
        out_nxt.removed_score_b = rem.score_b;
        out_nxt.removed_avg_x2  = AVG_W'(rem.score_a) + AVG_W'(rem.score_b);
      end else begin
        out_nxt.status = ST_NOT_FOUND;
      end
    end
    out_nxt.entry_count = ENTRY_W'(count_nxt);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

### sim/tb_sorted_key_table_insert_delete.sv
// Testbench for the sorted key table: directed and random insert/delete traffic, predicted results.
`timescale 1ns / 100ps
module tb_sorted_key_table_insert_delete;
  import skt_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_OPS   = 750;
  localparam int PHASES       = 4;
  localparam int REPORT_LIMIT = 10;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  // Track table contents and the queue of results still owed by the block
  class sorted_table_tracker;
    rec_t      table_q[$];
    out_item_t owed_results[$];
    int        errors;

    function int count();
      return table_q.size();
    endfunction

    function logic [KEY_W-1:0] key_at(int idx);
      return table_q[idx].key;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Apply one accepted operation and queue the result it must produce
    function void note_op(in_item_t op);
      out_item_t res;
      rec_t      fresh;
      int        pos;
      res = '0;
      if (op.cmd == CMD_INSERT) begin
        if (table_q.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < table_q.size() && op.student_key > table_q[pos].key) pos++;
          fresh.key     = op.student_key;
          fresh.score_a = op.score_a;
          fresh.score_b = op.score_b;
          table_q.insert(pos, fresh);
          res.status = ST_INSERTED;
        end
      end else begin
        pos = 0;
        while (pos < table_q.size() && table_q[pos].key != op.student_key) pos++;
        if (pos >= table_q.size()) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.status          = ST_DELETED;
          res.removed_score_a = table_q[pos].score_a;
          res.removed_score_b = table_q[pos].score_b;
          res.removed_avg_x2  = AVG_W'(table_q[pos].score_a) + AVG_W'(table_q[pos].score_b);
          table_q.delete(pos);
        end
      end
      res.entry_count = ENTRY_W'(table_q.size());
      owed_results.push_back(res);
    endfunction

    // Compare one result against the oldest owed result
    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result: status=%0d count=%0d a=%0d b=%0d avg=%0d",
                   got.status, got.entry_count, got.removed_score_a,
                   got.removed_score_b, got.removed_avg_x2);
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status || got.entry_count !== want.entry_count ||
          got.removed_score_a !== want.removed_score_a ||
          got.removed_score_b !== want.removed_score_b ||
          got.removed_avg_x2 !== want.removed_avg_x2) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("mismatch: expected status=%0d count=%0d a=%0d b=%0d avg=%0d",
                   want.status, want.entry_count, want.removed_score_a,
                   want.removed_score_b, want.removed_avg_x2);
          $display("          got      status=%0d count=%0d a=%0d b=%0d avg=%0d",
                   got.status, got.entry_count, got.removed_score_a,
                   got.removed_score_b, got.removed_avg_x2);
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  sorted_table_tracker tracker;
  logic [KEY_W-1:0]    key_pool[8];
  bit                  filling;
  int                  idle_pct;
  int                  stall_cycles;

  sorted_key_table_insert_delete dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #HALF_PERIOD clk = ~clk;

  // Check every result strobe
  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) tracker.check_result(out_item);
  end

  // Watchdog: end the run after too many cycles without a transfer
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (rst_n && stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic in_item_t random_bits();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return in_item_t'(raw[$bits(in_item_t)-1:0]);
  endfunction

  // Present one operation and hold it until the block takes it
  task automatic send_op(in_item_t op);
    @(negedge clk);
    start   <= 1'b1;
    in_item <= op;
    forever begin
      @(posedge clk);
      if (busy === 1'b0) break;
    end
    tracker.note_op(op);
  endtask

  // Leave the input channel empty, with start low and random data on in_item
  task automatic idle_cycle();
    @(negedge clk);
    start   <= 1'b0;
    in_item <= random_bits();
    @(posedge clk);
  endtask

  // Hold off the sender until every owed result has come back
  task automatic drain();
    idle_cycle();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic send_fields(logic cmd, logic [KEY_W-1:0] key,
                             logic [SCORE_W-1:0] sa, logic [SCORE_W-1:0] sb);
    in_item_t op;
    op = '{cmd: cmd, student_key: key, score_a: sa, score_b: sb};
    send_op(op);
  endtask

  // Swing the table between empty and full; deletes mostly hit stored keys
  function automatic in_item_t make_random_op();
    in_item_t op;
    int       ins_pct;
    op = random_bits();
    if (tracker.count() >= CAPACITY) filling = 1'b0;
    if (tracker.count() == 0) filling = 1'b1;
    ins_pct = filling ? 75 : 25;
    if ($urandom_range(99) < ins_pct) begin
      op.cmd = CMD_INSERT;
      if ($urandom_range(99) < 40) op.student_key = key_pool[$urandom_range(7)];
    end else begin
      op.cmd = CMD_DELETE;
      if (tracker.count() > 0 && $urandom_range(99) < 70)
        op.student_key = tracker.key_at($urandom_range(tracker.count() - 1));
      else if ($urandom_range(1) == 0)
        op.student_key = key_pool[$urandom_range(7)];
    end
    return op;
  endfunction

  // Extremes of keys and scores, duplicates, full table, empty table, missing key
  task automatic run_directed();
    int i;
    send_fields(CMD_DELETE, 30'h2AAA_AAAA, 8'hFF, 8'hFF);
    send_fields(CMD_INSERT, KEY_MAX, 8'hFF, 8'hFF);
    send_fields(CMD_INSERT, '0, 8'h00, 8'h00);
    send_fields(CMD_INSERT, 30'h2AAA_AAAA, 8'hAA, 8'h55);
    send_fields(CMD_INSERT, 30'h2AAA_AAAA, 8'h55, 8'hAA);
    for (i = 0; i < CAPACITY - 4; i++)
      send_fields(CMD_INSERT, KEY_W'(i * 7919 + 3), SCORE_W'(i * 17), SCORE_W'(255 - i));
    send_fields(CMD_INSERT, 30'h1555_5555, 8'h12, 8'h34);
    send_fields(CMD_DELETE, 30'h2AAA_AAAA, 8'h00, 8'h00);
    send_fields(CMD_DELETE, 30'h2AAA_AAAA, 8'hFF, 8'h00);
    send_fields(CMD_DELETE, 30'h2AAA_AAAA, 8'h00, 8'hFF);
    send_fields(CMD_DELETE, KEY_MAX, 8'h5A, 8'hA5);
    send_fields(CMD_DELETE, '0, 8'hFF, 8'hFF);
  endtask

  initial begin
    int phase;
    int n;
    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    stall_cycles = 0;
    filling      = 1'b1;
    tracker      = new();
    key_pool[0]  = '0;
    key_pool[1]  = KEY_MAX;
    for (n = 2; n < 8; n++) key_pool[n] = KEY_W'($urandom);

    // Hold reset low, then release it at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    drain();

    // Phases: no gaps, heavy sender gaps, moderate sender gaps, no gaps
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1:       idle_pct = 46;
        2:       idle_pct = 36;
        default: idle_pct = 0;
      endcase
      for (n = 0; n < RANDOM_OPS / PHASES; n++) begin
        while ($urandom_range(99) < idle_pct) idle_cycle();
        send_op(make_random_op());
      end
      drain();
    end

    // Wait for any stray strobe before the final verdict
    repeat (4) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/skt_pkg.sv
hw/rtl/skt_cell.sv
hw/rtl/sorted_key_table_insert_delete.sv
sim/tb_sorted_key_table_insert_delete.sv
